@@ design/rip_rte_pkg.sv @@
// Package with the types, codes and helpers shared by the RIP route table engine.
`default_nettype none

package rip_rte_pkg;

   // Protocol constants.
   localparam logic [4:0] RIP_INFINITY   = 5'd16;
   localparam logic [5:0] MAX_RESULTS    = 6'd32;
   localparam logic [7:0] CMD_REQUEST    = 8'd1;
   localparam logic [7:0] CMD_RESPONSE   = 8'd2;
   localparam logic [7:0] VERSION_1      = 8'd1;
   localparam logic [7:0] VERSION_2      = 8'd2;

   typedef enum logic [1:0] {
      OP_HEADER    = 2'd0,
      OP_ENTRY     = 2'd1,
      OP_EXPIRE    = 2'd2,
      OP_ADVERTISE = 2'd3
   } opcode_type;

   typedef enum logic [3:0] {
      ST_HEADER_OK     = 4'd0,
      ST_COMMAND_ERROR = 4'd1,
      ST_VERSION_ERROR = 4'd2,
      ST_UPDATED       = 4'd3,
      ST_KEPT          = 4'd4,
      ST_INSERTED      = 4'd5,
      ST_DROPPED       = 4'd6,
      ST_FULL          = 4'd7,
      ST_IGNORED       = 4'd8,
      ST_EXPIRED       = 4'd9,
      ST_NO_MATCH      = 4'd10,
      ST_ADVERT_ENTRY  = 4'd11,
      ST_ADVERT_EMPTY  = 4'd12
   } status_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  command;
      logic [7:0]  version;
      logic [15:0] pad;
      logic [7:0]  iface;
      logic [31:0] dest;
      logic [31:0] mask;
      logic [31:0] next_hop;
      logic [31:0] metric;
      logic        last_entry;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [31:0] route_dest;
      logic [31:0] route_mask;
      logic [31:0] route_next_hop;
      logic [4:0]  route_metric;
      logic        packet_end;
      logic        last;
   } rsp_payload_type;

   // One table slot as stored in the route memory.
   typedef struct packed {
      logic [31:0] dest;
      logic [31:0] mask;
      logic [31:0] next_hop;
      logic [4:0]  metric;
      logic [7:0]  iface;
   } route_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SRCH_RD,
      S_SRCH_CHK,
      S_ACT,
      S_ADV_RD,
      S_ADV_CHK,
      S_ADV_FIN
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       clr_accept;
      logic       set_accept;
      logic       scan_start;
      logic       rd_issue;
      logic       hit_set;
      logic       commit;
      logic       emit_single;
      status_type emit_code;
      logic       hold_new;
      logic       emit_held;
      logic       held_last;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      opcode_type opcode;
      logic       hdr_bad;
      status_type hdr_code;
      logic       hdr_request;
      logic       accepting;
      logic       idx_zero;
      logic       match;
      status_type act_code;
      logic       adv_sel;
      logic       held_valid;
      logic       n_full;
      logic       out_free;
   } dp_stat_type;

   // Received metric plus one, saturated at infinity.
   function automatic logic [4:0] bump(input logic [31:0] met);
      logic [4:0] res;
      if (met >= 32'(RIP_INFINITY)) begin
         res = RIP_INFINITY;
      end else begin
         res = met[4:0] + 5'd1;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

@@ design/rip_rte_stream_if.sv @@
// Valid/ready stream interface carrying one transaction payload.
`default_nettype none

interface rip_rte_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ design/rip_rte_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rip_rte_ram #(
   parameter int unsigned WIDTH      = 8,
   parameter int unsigned DEPTH      = 32,
   parameter int unsigned ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_WIDTH-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]      wr_data,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_WIDTH-1:0] rd_addr,
   output logic      [WIDTH-1:0]      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule

`default_nettype wire

@@ design/rip_rte_ctrl.sv @@
// Controller state machine that sequences header checks, table scans and advertisements.
`default_nettype none

module rip_rte_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire rip_rte_pkg::dp_stat_type  stat,
   output rip_rte_pkg::ctrl_cmd_type      cmd
);
   import rip_rte_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.opcode)
               OP_HEADER: begin
                  if (stat.hdr_bad) begin
                     if (stat.out_free) begin
                        cmd.clr_accept  = 1'b1;
                        cmd.emit_single = 1'b1;
                        cmd.emit_code   = stat.hdr_code;
                        state_in        = S_IDLE;
                     end
                  end else if (stat.hdr_request) begin
                     cmd.clr_accept = 1'b1;
                     cmd.scan_start = 1'b1;
                     state_in       = S_ADV_RD;
                  end else if (stat.out_free) begin
                     cmd.set_accept  = 1'b1;
                     cmd.emit_single = 1'b1;
                     cmd.emit_code   = ST_HEADER_OK;
                     state_in        = S_IDLE;
                  end
               end
               OP_ENTRY: begin
                  if (!stat.accepting) begin
                     if (stat.out_free) begin
                        cmd.emit_single = 1'b1;
                        cmd.emit_code   = ST_IGNORED;
                        state_in        = S_IDLE;
                     end
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SRCH_RD;
                  end
               end
               OP_EXPIRE: begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SRCH_RD;
               end
               default: begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_ADV_RD;
               end
            endcase
         end
         S_SRCH_RD: begin
            if (stat.idx_zero) begin
               state_in = S_ACT;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in     = S_SRCH_CHK;
            end
         end
         S_SRCH_CHK: begin
            if (stat.match) begin
               cmd.hit_set = 1'b1;
               state_in    = S_ACT;
            end else if (stat.idx_zero) begin
               state_in = S_ACT;
            end else begin
               cmd.rd_issue = 1'b1;
            end
         end
         S_ACT: begin
            if (stat.out_free) begin
               cmd.commit      = 1'b1;
               cmd.emit_single = 1'b1;
               cmd.emit_code   = stat.act_code;
               state_in        = S_IDLE;
            end
         end
         S_ADV_RD: begin
            if (stat.idx_zero || stat.n_full) begin
               state_in = S_ADV_FIN;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in     = S_ADV_CHK;
            end
         end
         S_ADV_CHK: begin
            if (!stat.adv_sel) begin
               state_in = S_ADV_RD;
            end else if (stat.held_valid) begin
               if (stat.out_free) begin
                  cmd.emit_held = 1'b1;
                  cmd.hold_new  = 1'b1;
                  state_in      = S_ADV_RD;
               end
            end else begin
               cmd.hold_new = 1'b1;
               state_in     = S_ADV_RD;
            end
         end
         S_ADV_FIN: begin
            if (stat.out_free) begin
               if (stat.held_valid) begin
                  cmd.emit_held = 1'b1;
                  cmd.held_last = 1'b1;
               end else begin
                  cmd.emit_single = 1'b1;
                  cmd.emit_code   = ST_ADVERT_EMPTY;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule

`default_nettype wire

@@ design/rip_rte_dp.sv @@
// Datapath: request capture, route memory, scan index, held advertisement and result register.
`default_nettype none

module rip_rte_dp #(
   parameter int unsigned TABLE_DEPTH       = 32,
   parameter int unsigned ROUTES_PER_PACKET = 25
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rip_rte_pkg::req_payload_type  req_payload,
   input  wire rip_rte_pkg::ctrl_cmd_type     cmd,
   output rip_rte_pkg::dp_stat_type           stat,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output rip_rte_pkg::rsp_payload_type       rsp_payload
);
   import rip_rte_pkg::*;

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned RW = $bits(route_type);

   req_payload_type in_ff;
   logic [CW-1:0]   idx_ff;
   logic [CW-1:0]   count_ff;
   logic            accept_ff;
   logic            hit_ff;
   logic            held_valid_ff;
   logic [31:0]     held_dest_ff;
   logic [31:0]     held_mask_ff;
   logic [31:0]     held_nh_ff;
   logic [4:0]      held_metric_ff;
   logic [5:0]      n_ff;
   logic [4:0]      pkt_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff;

   logic [CW-1:0]   idx_dec;
   logic [RW-1:0]   ram_rdata;
   route_type       rd;
   route_type       wr_route;
   logic [AW-1:0]   wr_addr;
   logic            wr_ok;
   status_type      act_code;
   logic            cmd_ok;
   logic            ver_ok;
   logic            is_v2;
   logic            out_free;
   logic            held_pend;
   logic [4:0]      bumped;

   assign idx_dec  = idx_ff - CW'(1);
   assign rd       = route_type'(ram_rdata);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign bumped   = bump(in_ff.metric);
   assign is_v2    = (in_ff.version == VERSION_2);

   // Route memory, read while scanning from the newest slot down.
   rip_rte_ram #(
      .WIDTH (RW),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && wr_ok),
      .wr_addr (wr_addr),
      .wr_data (wr_route),
      .rd_en   (cmd.rd_issue),
      .rd_addr (idx_dec[AW-1:0]),
      .rd_data (ram_rdata)
   );

   // Header checks.
   always_comb begin
      cmd_ok = (in_ff.command == CMD_REQUEST) || (in_ff.command == CMD_RESPONSE);
      ver_ok = (in_ff.version == VERSION_1) || (in_ff.version == VERSION_2);
   end

   // Outcome of an entry or expire transaction and the slot it writes.
   always_comb begin
      wr_ok    = 1'b0;
      wr_addr  = hit_ff ? idx_ff[AW-1:0] : count_ff[AW-1:0];
      wr_route = '{dest: in_ff.dest, mask: in_ff.mask, next_hop: in_ff.next_hop,
                   metric: bumped, iface: in_ff.iface};
      act_code = ST_NO_MATCH;
      if (opcode_type'(in_ff.opcode) == OP_EXPIRE) begin
         wr_route        = rd;
         wr_route.metric = RIP_INFINITY;
         wr_ok           = hit_ff;
         act_code        = hit_ff ? ST_EXPIRED : ST_NO_MATCH;
      end else if (hit_ff) begin
         if (rd.next_hop != in_ff.next_hop && {27'd0, rd.metric} <= in_ff.metric) begin
            act_code = ST_KEPT;
         end else begin
            wr_ok    = 1'b1;
            act_code = ST_UPDATED;
         end
      end else if (in_ff.metric >= 32'(RIP_INFINITY)) begin
         act_code = ST_DROPPED;
      end else if (count_ff == CW'(TABLE_DEPTH)) begin
         act_code = ST_FULL;
      end else begin
         wr_ok    = 1'b1;
         act_code = ST_INSERTED;
      end
   end

   // Status toward the controller.
   always_comb begin
      stat.opcode      = opcode_type'(in_ff.opcode);
      stat.hdr_bad     = !cmd_ok || !ver_ok || (in_ff.pad != 16'd0);
      stat.hdr_code    = (cmd_ok && !ver_ok) ? ST_VERSION_ERROR : ST_COMMAND_ERROR;
      stat.hdr_request = (in_ff.command == CMD_REQUEST);
      stat.accepting   = accept_ff;
      stat.idx_zero    = (idx_ff == '0);
      stat.match       = (rd.dest == in_ff.dest) && (rd.mask == in_ff.mask);
      stat.act_code    = act_code;
      stat.adv_sel     = (rd.iface != in_ff.iface) && (rd.metric != RIP_INFINITY);
      stat.held_valid  = held_valid_ff;
      stat.n_full      = (n_ff == MAX_RESULTS);
      stat.out_free    = out_free;
   end

   assign held_pend = cmd.held_last || (pkt_ff == 5'(ROUTES_PER_PACKET - 1));

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         accept_ff     <= 1'b0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.clr_accept) begin
            accept_ff <= 1'b0;
         end
         if (cmd.set_accept) begin
            accept_ff <= 1'b1;
         end
         if (cmd.commit && opcode_type'(in_ff.opcode) == OP_ENTRY) begin
            if (in_ff.last_entry) begin
               accept_ff <= 1'b0;
            end
            if (!hit_ff && wr_ok) begin
               count_ff <= count_ff + CW'(1);
            end
         end
         if (cmd.scan_start) begin
            held_valid_ff <= 1'b0;
         end else if (cmd.hold_new) begin
            held_valid_ff <= 1'b1;
         end
         if (cmd.emit_single || cmd.emit_held) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Scan index, counters and payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         in_ff <= req_payload;
      end
      if (cmd.scan_start) begin
         idx_ff <= count_ff;
         hit_ff <= 1'b0;
         n_ff   <= '0;
         pkt_ff <= '0;
      end else begin
         if (cmd.rd_issue) begin
            idx_ff <= idx_dec;
         end
         if (cmd.hit_set) begin
            hit_ff <= 1'b1;
         end
         if (cmd.hold_new) begin
            n_ff <= n_ff + 6'd1;
         end
         if (cmd.emit_held) begin
            pkt_ff <= held_pend ? 5'd0 : pkt_ff + 5'd1;
         end
      end
      if (cmd.hold_new) begin
         held_dest_ff   <= rd.dest;
         held_mask_ff   <= is_v2 ? rd.mask : 32'd0;
         held_nh_ff     <= is_v2 ? rd.next_hop : 32'd0;
         held_metric_ff <= rd.metric;
      end
      if (cmd.emit_held) begin
         rsp_ff <= '{status: ST_ADVERT_ENTRY, route_dest: held_dest_ff,
                     route_mask: held_mask_ff, route_next_hop: held_nh_ff,
                     route_metric: held_metric_ff, packet_end: held_pend,
                     last: cmd.held_last};
      end else if (cmd.emit_single) begin
         rsp_ff <= '{status: cmd.emit_code, route_dest: 32'd0, route_mask: 32'd0,
                     route_next_hop: 32'd0, route_metric: 5'd0,
                     packet_end: (cmd.emit_code == ST_ADVERT_EMPTY), last: 1'b1};
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
endmodule

`default_nettype wire

@@ design/rip_route_table_engine_core.sv @@
// Top level of the RIP route table engine: controller, datapath and stream ports.
// A response header, a bad header or an ignored entry is answered straight from decode; an
// entry or expire scans the table from the newest slot down, and a match ends the scan early;
// a request header or advertisement scans the table for up to 32 advert results.
// One transaction at a time; the next is taken from the cycle after its final result is registered.
// Synchronous reset empties the table (route count zero) and closes response acceptance.
`default_nettype none

module rip_route_table_engine_core #(
   parameter int unsigned TABLE_DEPTH       = 32,
   parameter int unsigned ROUTES_PER_PACKET = 25
) (
   input  wire logic         clock,
   input  wire logic         reset,
   rip_rte_stream_if.sink    req,
   rip_rte_stream_if.source  rsp
);
   import rip_rte_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   // Sequencing.
   rip_rte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Table, scan and result datapath.
   rip_rte_dp #(
      .TABLE_DEPTH       (TABLE_DEPTH),
      .ROUTES_PER_PACKET (ROUTES_PER_PACKET)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req.payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp.valid),
      .rsp_ready   (rsp.ready),
      .rsp_payload (rsp.payload)
   );
endmodule

`default_nettype wire

@@ tb/tb_rip_route_table_engine_core.sv @@
// Testbench for the RIP route table engine core: directed and random transactions checked against a predictor.
`default_nettype none

module tb_rip_route_table_engine_core;
   import rip_rte_pkg::*;

   localparam int DEPTH = 32;
   localparam int PER_PACKET = 25;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rip_rte_stream_if #(.payload_type(req_payload_type)) req_ch ();
   rip_rte_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   rip_route_table_engine_core dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   // Clock with a 12 unit period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predicted route table.
   logic [31:0] rt_dest[DEPTH];
   logic [31:0] rt_mask[DEPTH];
   logic [31:0] rt_hop[DEPTH];
   logic [4:0]  rt_metric[DEPTH];
   logic [7:0]  rt_iface[DEPTH];
   int          rt_count;
   bit          rt_accepting;

   rsp_payload_type expected_routes[$];
   int  error_count = 0;
   int  rsp_seen = 0;
   int  sent_count = 0;
   int  adverts_seen = 0;

   function automatic rsp_payload_type one_status(status_type st);
      rsp_payload_type r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic int find_slot(logic [31:0] d, logic [31:0] m);
      for (int i = rt_count - 1; i >= 0; i--) begin
         if (rt_dest[i] == d && rt_mask[i] == m) return i;
      end
      return -1;
   endfunction

   function automatic logic [4:0] hop_plus_one(logic [31:0] met);
      if (met >= 32'd16) return RIP_INFINITY;
      return met[4:0] + 5'd1;
   endfunction

   // Queue the advertisement of the table, newest route first.
   function automatic void predict_advert(logic [7:0] ver, logic [7:0] ifc);
      int sel[$];
      rsp_payload_type r;
      for (int i = rt_count - 1; i >= 0 && sel.size() < 32; i--) begin
         if (rt_iface[i] != ifc && rt_metric[i] != RIP_INFINITY) sel.push_back(i);
      end
      if (sel.size() == 0) begin
         r = one_status(ST_ADVERT_EMPTY);
         r.packet_end = 1'b1;
         expected_routes.push_back(r);
         return;
      end
      foreach (sel[k]) begin
         r = '0;
         r.status = ST_ADVERT_ENTRY;
         r.route_dest = rt_dest[sel[k]];
         r.route_mask = (ver == VERSION_2) ? rt_mask[sel[k]] : 32'd0;
         r.route_next_hop = (ver == VERSION_2) ? rt_hop[sel[k]] : 32'd0;
         r.route_metric = rt_metric[sel[k]];
         r.last = (k == sel.size() - 1);
         r.packet_end = r.last || ((k + 1) % PER_PACKET == 0);
         expected_routes.push_back(r);
      end
   endfunction

   function automatic status_type predict_entry(req_payload_type q);
      int h;
      h = find_slot(q.dest, q.mask);
      if (h >= 0) begin
         if (rt_hop[h] != q.next_hop) begin
            if (32'(rt_metric[h]) > q.metric) begin
               rt_metric[h] = hop_plus_one(q.metric);
               rt_hop[h] = q.next_hop;
               rt_iface[h] = q.iface;
               return ST_UPDATED;
            end
            return ST_KEPT;
         end
         rt_metric[h] = hop_plus_one(q.metric);
         rt_iface[h] = q.iface;
         return ST_UPDATED;
      end
      if (q.metric >= 32'd16) return ST_DROPPED;
      if (rt_count >= DEPTH) return ST_FULL;
      rt_dest[rt_count] = q.dest;
      rt_mask[rt_count] = q.mask;
      rt_hop[rt_count] = q.next_hop;
      rt_metric[rt_count] = q.metric[4:0] + 5'd1;
      rt_iface[rt_count] = q.iface;
      rt_count++;
      return ST_INSERTED;
   endfunction

   // Work out the results of one accepted transaction.
   function automatic void predict_routes(req_payload_type q);
      int h;
      case (opcode_type'(q.opcode))
         OP_HEADER: begin
            rt_accepting = 1'b0;
            if (q.command != CMD_REQUEST && q.command != CMD_RESPONSE)
               expected_routes.push_back(one_status(ST_COMMAND_ERROR));
            else if (q.version != VERSION_1 && q.version != VERSION_2)
               expected_routes.push_back(one_status(ST_VERSION_ERROR));
            else if (q.pad != 16'd0)
               expected_routes.push_back(one_status(ST_COMMAND_ERROR));
            else if (q.command == CMD_REQUEST)
               predict_advert(q.version, q.iface);
            else begin
               rt_accepting = 1'b1;
               expected_routes.push_back(one_status(ST_HEADER_OK));
            end
         end
         OP_ENTRY: begin
            if (!rt_accepting) begin
               expected_routes.push_back(one_status(ST_IGNORED));
            end else begin
               expected_routes.push_back(one_status(predict_entry(q)));
               if (q.last_entry) rt_accepting = 1'b0;
            end
         end
         OP_EXPIRE: begin
            h = find_slot(q.dest, q.mask);
            if (h < 0) begin
               expected_routes.push_back(one_status(ST_NO_MATCH));
            end else begin
               rt_metric[h] = RIP_INFINITY;
               expected_routes.push_back(one_status(ST_EXPIRED));
            end
         end
         default: predict_advert(q.version, q.iface);
      endcase
   endfunction

   // Sender: bursts of random length, most of them separated by random gaps.
   int burst_left = 0;

   task automatic send_item(req_payload_type q);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         if ($urandom_range(0, 2) != 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.payload <= q;
      do @(posedge clock); while (!req_ch.ready);
      predict_routes(q);
      sent_count++;
      @(negedge clock);
   endtask

   // Receiver stalls in a pattern: runs of ready, then random stalls.
   int stall_phase = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         stall_phase <= (stall_phase + 1) % 40;
         if (stall_phase < 15) rsp_ch.ready <= 1'b1;
         else rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Compare each result against the oldest expectation.
   always @(posedge clock) begin
      rsp_payload_type exp_r;
      rsp_payload_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         rsp_seen++;
         if (got.status == ST_ADVERT_ENTRY) adverts_seen++;
         if (expected_routes.size() == 0) begin
            $error("unexpected transaction, status %0d", got.status);
            error_count++;
         end else begin
            exp_r = expected_routes.pop_front();
            if (got.status !== exp_r.status) begin
               $error("status expected %0d actual %0d", exp_r.status, got.status);
               error_count++;
            end
            if (got.route_dest !== exp_r.route_dest) begin
               $error("route_dest expected %h actual %h", exp_r.route_dest, got.route_dest);
               error_count++;
            end
            if (got.route_mask !== exp_r.route_mask) begin
               $error("route_mask expected %h actual %h", exp_r.route_mask, got.route_mask);
               error_count++;
            end
            if (got.route_next_hop !== exp_r.route_next_hop) begin
               $error("route_next_hop expected %h actual %h", exp_r.route_next_hop,
                      got.route_next_hop);
               error_count++;
            end
            if (got.route_metric !== exp_r.route_metric) begin
               $error("route_metric expected %0d actual %0d", exp_r.route_metric,
                      got.route_metric);
               error_count++;
            end
            if (got.packet_end !== exp_r.packet_end) begin
               $error("packet_end expected %0d actual %0d", exp_r.packet_end, got.packet_end);
               error_count++;
            end
            if (got.last !== exp_r.last) begin
               $error("last expected %0d actual %0d", exp_r.last, got.last);
               error_count++;
            end
         end
      end
   end

   // Item builders.
   function automatic req_payload_type make_header(logic [7:0] cmd, logic [7:0] ver,
                                                   logic [15:0] pad, logic [7:0] ifc);
      req_payload_type q;
      q = '0;
      q.opcode = OP_HEADER;
      q.command = cmd;
      q.version = ver;
      q.pad = pad;
      q.iface = ifc;
      return q;
   endfunction

   function automatic req_payload_type make_route(opcode_type op, logic [31:0] d,
                                                  logic [31:0] m, logic [31:0] nh,
                                                  logic [31:0] met, logic [7:0] ifc,
                                                  logic lst);
      req_payload_type q;
      q = '0;
      q.opcode = op;
      q.dest = d;
      q.mask = m;
      q.next_hop = nh;
      q.metric = met;
      q.iface = ifc;
      q.last_entry = lst;
      q.command = $urandom;
      q.version = $urandom;
      return q;
   endfunction

   function automatic req_payload_type make_advert(logic [7:0] ver, logic [7:0] ifc);
      req_payload_type q;
      q = '0;
      q.opcode = OP_ADVERTISE;
      q.version = ver;
      q.iface = ifc;
      q.dest = $urandom;
      return q;
   endfunction

   // Header checks, every status of an entry but full, expire and empty advertisements.
   task automatic test_directed();
      send_item(make_advert(VERSION_2, 8'd0));
      send_item(make_header(8'd0, VERSION_2, 16'd0, 8'd1));
      send_item(make_header(8'd255, 8'd255, 16'hFFFF, 8'd255));
      send_item(make_header(CMD_RESPONSE, 8'd0, 16'd0, 8'd1));
      send_item(make_header(CMD_RESPONSE, 8'd3, 16'd0, 8'd1));
      send_item(make_header(CMD_REQUEST, VERSION_1, 16'h8000, 8'd1));
      send_item(make_route(OP_ENTRY, 32'h0A000000, 32'hFF000000, 32'h1, 32'd1, 8'd1, 1'b0));
      send_item(make_header(CMD_RESPONSE, VERSION_2, 16'd0, 8'd3));
      send_item(make_route(OP_ENTRY, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0,
                           8'd255, 1'b0));
      send_item(make_route(OP_ENTRY, 32'h0A000000, 32'hFF000000, 32'h1, 32'd15, 8'd3, 1'b0));
      send_item(make_route(OP_ENTRY, 32'h0A000000, 32'hFF000000, 32'h2, 32'd3, 8'd4, 1'b0));
      send_item(make_route(OP_ENTRY, 32'h0A000000, 32'hFF000000, 32'h3, 32'd9, 8'd5, 1'b0));
      send_item(make_route(OP_ENTRY, 32'h0A000000, 32'hFF000000, 32'h2, 32'hFFFFFFFF,
                           8'd6, 1'b0));
      send_item(make_route(OP_ENTRY, 32'h0B000000, 32'd0, 32'd0, 32'd16, 8'd3, 1'b0));
      send_item(make_route(OP_ENTRY, 32'h0, 32'h0, 32'h0, 32'd4, 8'd0, 1'b1));
      send_item(make_route(OP_ENTRY, 32'h0C000000, 32'd0, 32'd0, 32'd1, 8'd0, 1'b0));
      send_item(make_route(OP_EXPIRE, 32'h0D000000, 32'd0, 32'd0, 32'd0, 8'd0, 1'b0));
      send_item(make_route(OP_EXPIRE, 32'h0A000000, 32'hFF000000, 32'd0, 32'd0, 8'd0, 1'b0));
      send_item(make_header(CMD_REQUEST, VERSION_1, 16'd0, 8'd255));
      send_item(make_header(CMD_REQUEST, VERSION_2, 16'd0, 8'd0));
      send_item(make_advert(8'd7, 8'd9));
   endtask

   // Fill past the table depth so full and long advertisements are reached.
   task automatic test_fill_table();
      send_item(make_header(CMD_RESPONSE, VERSION_2, 16'd0, 8'd7));
      for (int i = 0; i < DEPTH + 3; i++)
         send_item(make_route(OP_ENTRY, 32'hC0A80000 + i, $urandom, $urandom,
                              $urandom_range(0, 15), $urandom_range(1, 3), i == DEPTH + 2));
      send_item(make_advert(VERSION_2, 8'd200));
      send_item(make_header(CMD_REQUEST, VERSION_1, 16'd0, 8'd1));
      send_item(make_advert(VERSION_2, 8'd2));
   endtask

   // Random traffic: about half well-formed response packets, with noise mixed in.
   task automatic test_random_traffic();
      logic [31:0] d;
      logic [31:0] m;
      int n;
      int j;
      while (sent_count < 280) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               send_item(make_header(CMD_RESPONSE, $urandom_range(1, 2), 16'd0, $urandom_range(0, 3)));
               n = $urandom_range(1, 6);
               for (int k = 0; k < n; k++) begin
                  if ($urandom_range(0, 2) == 0) begin
                     d = 32'hC0A80000 + $urandom_range(0, 40);
                     m = (rt_count > 0 && $urandom_range(0, 1)) ? rt_mask[d[4:0] % rt_count] : 0;
                     if (rt_count > 0 && $urandom_range(0, 1)) begin
                        j = $urandom_range(0, rt_count - 1);
                        d = rt_dest[j];
                        m = rt_mask[j];
                     end
                  end else begin
                     d = $urandom;
                     m = $urandom;
                  end
                  send_item(make_route(OP_ENTRY, d, m,
                                       $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2),
                                       $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 17),
                                       $urandom_range(0, 3), k == n - 1));
               end
            end
            5: begin
               if (rt_count > 0 && $urandom_range(0, 2) != 0) begin
                  n = $urandom_range(0, rt_count - 1);
                  send_item(make_route(OP_EXPIRE, rt_dest[n], rt_mask[n], $urandom, $urandom,
                                       $urandom, $urandom));
               end else begin
                  send_item(make_route(OP_EXPIRE, $urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom));
               end
            end
            6: send_item(make_advert($urandom_range(0, 1) ? $urandom_range(1, 2) : $urandom,
                                     $urandom_range(0, 4)));
            7: send_item(make_header($urandom_range(0, 3), $urandom_range(0, 3),
                                     $urandom_range(0, 1) ? 16'd0 : $urandom,
                                     $urandom_range(0, 255)));
            8: send_item(make_header($urandom, $urandom, $urandom, $urandom));
            default: send_item(make_route(OP_ENTRY, $urandom, $urandom, $urandom, $urandom,
                                          $urandom, $urandom));
         endcase
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      rt_count = 0;
      rt_accepting = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill_table();
      test_random_traffic();
      req_ch.valid <= 1'b0;
      while (expected_routes.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Sent %0d transactions, checked %0d results (%0d advertised routes).",
               sent_count, rsp_seen, adverts_seen);
      $display("Covered header errors, every entry status, expiry, full table and long adverts.");
      if (error_count == 0 && expected_routes.size() == 0)
         $display("PASS rip_route_table_engine_core");
      else
         $display("FAIL rip_route_table_engine_core");
      $finish;
   end

   // Overall time limit.
   initial begin
      #6000000;
      $display("FAIL rip_route_table_engine_core");
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
design/rip_rte_pkg.sv
design/rip_rte_stream_if.sv
design/rip_rte_ram.sv
design/rip_rte_ctrl.sv
design/rip_rte_dp.sv
design/rip_route_table_engine_core.sv
tb/tb_rip_route_table_engine_core.sv
